FILE: hw/rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, register indexes and the open-circuit-voltage curve.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int MV_W      = 13;
    localparam int PCT_W     = 7;
    localparam int DROP_W    = 10;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam int AVG_DEPTH_DEF = 8;
    localparam int CURVE_LEN_DEF = 17;
    localparam int CURVE_MAX     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_ENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_EXIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_DROP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM      = 3'd4;

    localparam logic [MV_W-1:0]  VALID_MIN_RST    = 13'd2800;
    localparam logic [MV_W-1:0]  CHARGE_ENTER_RST = 13'd4250;
    localparam logic [MV_W-1:0]  CHARGE_EXIT_RST  = 13'd4150;
    localparam logic [DROP_W-1:0] CHARGE_DROP_RST = 10'd100;
    localparam logic [CNT_W-1:0] CONFIRM_RST      = 4'd2;
    localparam logic [PCT_W-1:0] PCT_MAX          = 7'd100;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // store reading, update count/index
        logic sum_step; // add one window entry
        logic div_init;
        logic div_step;
        logic avg_load; // take the average from the first divide
        logic seg_step; // advance curve segment search
        logic ip_init;
        logic finish;   // commit state and result
    } bse_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_done;
        logic seg_done;
    } bse_sts_t;

    function automatic logic [MV_W-1:0] curve_mv(input int i);
        logic [MV_W-1:0] v;
        case (i)
            0: v = 13'd3300;  1: v = 13'd3400;  2: v = 13'd3500;  3: v = 13'd3550;
            4: v = 13'd3600;  5: v = 13'd3650;  6: v = 13'd3700;  7: v = 13'd3750;
            8: v = 13'd3800;  9: v = 13'd3850;  10: v = 13'd3900; 11: v = 13'd3950;
            12: v = 13'd4000; 13: v = 13'd4050; 14: v = 13'd4100; 15: v = 13'd4150;
            default: v = 13'd4200;
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] curve_pct(input int i);
        logic [PCT_W-1:0] p;
        case (i)
            0: p = 7'd0;   1: p = 7'd5;   2: p = 7'd10;  3: p = 7'd15;
            4: p = 7'd20;  5: p = 7'd28;  6: p = 7'd40;  7: p = 7'd48;
            8: p = 7'd55;  9: p = 7'd62;  10: p = 7'd70; 11: p = 7'd76;
            12: p = 7'd82; 13: p = 7'd88; 14: p = 7'd93; 15: p = 7'd97;
            default: p = 7'd100;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/battery_soc_estimator.sv
// ----------------------------------------------------------------------------
// battery_soc_estimator
// Running-average battery voltage to state-of-charge estimator.
// ----------------------------------------------------------------------------
// One reading at a time: after a request is accepted the block sums the window,
// runs a one-bit-per-cycle divider for the average, registers the clamped cell
// voltage, searches the curve segments, divides again for the interpolation and
// commits. The result is held on the output until taken; the next request can be
// accepted while it waits, but that request's commit stalls until the previous
// result has gone.
module battery_soc_estimator
#(
    parameter int AVG_DEPTH = bse_pkg::AVG_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bse_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bse_pkg::MV_W-1:0]      reading_mv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bse_pkg::MV_W-1:0]      average_mv,
    output logic [bse_pkg::PCT_W-1:0]     percent,
    output logic                          charging,
    output logic                          updated
);
    import bse_pkg::*;

    logic [MV_W-1:0]   valid_min_reg, enter_reg, exit_reg;
    logic [DROP_W-1:0] drop_reg;
    logic [CNT_W-1:0]  confirm_reg;
    bse_cmd_t          cmd;
    bse_sts_t          sts;
    logic              busy;
    logic              out_vld_reg;
    logic              in_fire, out_fire, out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign out_free  = !out_vld_reg || out_ready;
    assign out_valid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_min_reg <= VALID_MIN_RST;
            enter_reg     <= CHARGE_ENTER_RST;
            exit_reg      <= CHARGE_EXIT_RST;
            drop_reg      <= CHARGE_DROP_RST;
            confirm_reg   <= CONFIRM_RST;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_VALID_MIN:    valid_min_reg <= cfg_data;
                    REG_CHARGE_ENTER: enter_reg     <= cfg_data;
                    REG_CHARGE_EXIT:  exit_reg      <= cfg_data;
                    REG_CHARGE_DROP:  drop_reg      <= cfg_data[DROP_W-1:0];
                    REG_CONFIRM:      confirm_reg   <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.finish)
                out_vld_reg <= 1'b1;
            else if (out_fire)
                out_vld_reg <= 1'b0;
        end
    end

    bse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    bse_dp #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .reading_mv      (reading_mv),
        .valid_min_mv    (valid_min_reg),
        .charge_enter_mv (enter_reg),
        .charge_exit_mv  (exit_reg),
        .charge_drop_mv  (drop_reg),
        .confirm_count   (confirm_reg),
        .average_mv      (average_mv),
        .percent         (percent),
        .charging        (charging),
        .updated         (updated)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
        out_valid && $stable({average_mv, percent, charging, updated}))
        else $error("result changed while waiting");
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        percent <= PCT_MAX)
        else $error("percent out of range");
    a_slew: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_fire) && out_fire && updated && $past(updated) |->
        (percent == $past(percent) || percent == $past(percent) + 7'd1
         || percent == $past(percent) - 7'd1))
        else $error("percent moved by more than one");
`endif

endmodule

FILE: hw/rtl/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: load, sum, divide, cell voltage, curve search, interpolation
// divide, commit.
// ----------------------------------------------------------------------------
module bse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_free,
    input  bse_pkg::bse_sts_t sts,
    output bse_pkg::bse_cmd_t cmd,
    output logic              busy
);
    import bse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_DIV1, S_CELL, S_SEG, S_DIV2, S_DONE
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_fire) state_reg <= S_SUM;
                S_SUM:  if (sts.sum_done) state_reg <= S_DIV1;
                S_DIV1: if (sts.div_done) state_reg <= S_CELL;
                S_CELL: state_reg <= S_SEG;
                S_SEG:  if (sts.seg_done) state_reg <= S_DIV2;
                S_DIV2: if (sts.div_done) state_reg <= S_DONE;
                S_DONE: if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_fire;
        cmd.sum_step = (state_reg == S_SUM);
        cmd.div_init = (state_reg == S_SUM) && sts.sum_done;
        cmd.div_step = (state_reg == S_DIV1) || (state_reg == S_DIV2);
        cmd.avg_load = (state_reg == S_DIV1) && sts.div_done;
        cmd.seg_step = (state_reg == S_SEG);
        cmd.ip_init  = (state_reg == S_SEG) && sts.seg_done;
        // commit waits until the previous result has been taken
        cmd.finish   = (state_reg == S_DONE) && out_free;
        busy         = (state_reg != S_IDLE);
    end

endmodule

FILE: hw/rtl/bse_dp.sv
// ----------------------------------------------------------------------------
// bse_dp
// Datapath: reading window, serial sum, shared restoring divider, curve
// search, hysteresis and slew-limited percent.
// ----------------------------------------------------------------------------
module bse_dp
#(
    parameter int AVG_DEPTH = bse_pkg::AVG_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bse_pkg::bse_cmd_t          cmd,
    output bse_pkg::bse_sts_t          sts,
    input  logic [bse_pkg::MV_W-1:0]   reading_mv,
    input  logic [bse_pkg::MV_W-1:0]   valid_min_mv,
    input  logic [bse_pkg::MV_W-1:0]   charge_enter_mv,
    input  logic [bse_pkg::MV_W-1:0]   charge_exit_mv,
    input  logic [bse_pkg::DROP_W-1:0] charge_drop_mv,
    input  logic [bse_pkg::CNT_W-1:0]  confirm_count,
    output logic [bse_pkg::MV_W-1:0]   average_mv,
    output logic [bse_pkg::PCT_W-1:0]  percent,
    output logic                       charging,
    output logic                       updated
);
    import bse_pkg::*;

    localparam int CURVE_LEN = CURVE_LEN_DEF;
    localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CNT_SW = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W = MV_W + $clog2(AVG_DEPTH + 1);
    localparam int SEG_W = $clog2(CURVE_LEN);
    localparam int DIV_W = SUM_W + 1;
    localparam int DST_W = $clog2(DIV_W + 1);
    localparam logic [CNT_SW-1:0] DEPTH_C = CNT_SW'(AVG_DEPTH);
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(CURVE_LEN - 1);

    logic [MV_W-1:0]   buf_mem [AVG_DEPTH];
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [CNT_SW-1:0] cnt_reg;
    logic [CNT_SW-1:0] rd_cnt_reg;
    logic [MV_W-1:0]   rd_data_reg;
    logic              rd_vld_reg;
    logic [SUM_W-1:0]  sum_reg;

    // restoring divider, one quotient bit per cycle
    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DST_W-1:0]  dcnt_reg;
    logic [DIV_W:0]    rem_sh;
    logic [DIV_W:0]    rem_sub;

    logic [MV_W-1:0]   avg_reg;
    logic [MV_W-1:0]   cell_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic              want_next, state_next;
    logic [CNT_W-1:0]  streak_reg, streak_next;
    logic              chg_reg;
    logic [PCT_W-1:0]  shown_reg, shown_next, target;
    logic              primed_reg;
    logic [MV_W-1:0]   held_reg;
    logic              upd_reg;
    logic [MV_W-1:0]   seg_v1, seg_v0;
    logic [PCT_W-1:0]  seg_p1, seg_p0;
    logic [MV_W:0]     cell_raw;
    logic [MV_W-1:0]   cell_clamp;

    assign sts.sum_done = (rd_cnt_reg == cnt_reg) && !rd_vld_reg;
    assign sts.div_done = (dcnt_reg == '0);
    assign sts.seg_done = (cell_reg <= curve_mv(int'(seg_reg))) || (seg_reg == SEG_LAST);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            buf_mem[wr_idx_reg] <= reading_mv;
        rd_data_reg <= buf_mem[rd_cnt_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_comb
    begin
        seg_v1 = curve_mv(int'(seg_reg));
        seg_v0 = curve_mv(int'(seg_reg) - 1);
        seg_p1 = curve_pct(int'(seg_reg));
        seg_p0 = curve_pct(int'(seg_reg) - 1);

        want_next = chg_reg;
        if (!chg_reg && avg_reg > charge_enter_mv)
            want_next = 1'b1;
        else if (chg_reg && avg_reg < charge_exit_mv)
            want_next = 1'b0;
        state_next  = chg_reg;
        streak_next = '0;
        if (want_next != chg_reg)
        begin
            streak_next = streak_reg + 1'b1;
            if (streak_next >= confirm_count)
            begin
                state_next  = want_next;
                streak_next = '0;
            end
        end

        cell_raw = {1'b0, avg_reg};
        if (state_next || avg_reg > charge_enter_mv)
            cell_raw = {1'b0, avg_reg} - {4'd0, charge_drop_mv};
        if (cell_raw[MV_W] || cell_raw[MV_W-1:0] < curve_mv(0))
            cell_clamp = curve_mv(0);
        else if (cell_raw[MV_W-1:0] > curve_mv(CURVE_LEN - 1))
            cell_clamp = curve_mv(CURVE_LEN - 1);
        else
            cell_clamp = cell_raw[MV_W-1:0];

        if (cell_reg <= curve_mv(0))
            target = curve_pct(0);
        else if (cell_reg >= curve_mv(CURVE_LEN - 1))
            target = curve_pct(CURVE_LEN - 1);
        else
            target = seg_p0 + PCT_W'(quo_reg);

        shown_next = shown_reg;
        if (!primed_reg)
            shown_next = target;
        else if (target > shown_reg)
            shown_next = shown_reg + 1'b1;
        else if (target < shown_reg)
            shown_next = shown_reg - 1'b1;
        if (shown_next > PCT_MAX)
            shown_next = PCT_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            cnt_reg    <= '0;
            rd_cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            sum_reg    <= '0;
            num_reg    <= '0;
            den_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            dcnt_reg   <= '0;
            streak_reg <= '0;
            chg_reg    <= 1'b0;
            shown_reg  <= '0;
            primed_reg <= 1'b0;
            held_reg   <= '0;
            upd_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= 1'b0;
            if (cmd.load)
            begin
                wr_idx_reg <= (32'(wr_idx_reg) == AVG_DEPTH - 1) ? '0 : wr_idx_reg + 1'b1;
                if (cnt_reg != DEPTH_C)
                    cnt_reg <= cnt_reg + 1'b1;
                rd_cnt_reg <= '0;
                sum_reg    <= '0;
            end
            if (cmd.sum_step)
            begin
                if (rd_cnt_reg != cnt_reg)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    rd_vld_reg <= 1'b1;
                end
                if (rd_vld_reg)
                    sum_reg <= sum_reg + SUM_W'(rd_data_reg);
            end
            if (cmd.div_init)
            begin
                num_reg  <= DIV_W'(sum_reg);
                den_reg  <= DIV_W'(cnt_reg);
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= DST_W'(DIV_W);
            end
            else if (cmd.ip_init)
            begin
                // (2*off*dp + span) / (2*span)
                num_reg  <= DIV_W'((2 * 32'(cell_reg - seg_v0) * 32'(seg_p1 - seg_p0))
                                   + 32'(seg_v1 - seg_v0));
                den_reg  <= DIV_W'(2 * 32'(seg_v1 - seg_v0));
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= DST_W'(DIV_W);
            end
            else if (cmd.div_step && dcnt_reg != '0)
            begin
                num_reg  <= num_reg << 1;
                dcnt_reg <= dcnt_reg - 1'b1;
                if (!rem_sub[DIV_W])
                begin
                    rem_reg <= rem_sub[DIV_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[DIV_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
            end
            if (cmd.finish)
            begin
                if (avg_reg < valid_min_mv)
                    upd_reg <= 1'b0;
                else
                begin
                    upd_reg    <= 1'b1;
                    chg_reg    <= state_next;
                    streak_reg <= streak_next;
                    shown_reg  <= shown_next;
                    primed_reg <= 1'b1;
                    held_reg   <= avg_reg;
                end
            end
        end
    end

    // average latches when the first divide ends, segment search starts at 1
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
            seg_reg <= SEG_W'(1);
        if (cmd.seg_step && !sts.seg_done)
            seg_reg <= seg_reg + 1'b1;
        if (cmd.avg_load)
            avg_reg <= quo_reg[MV_W-1:0];
    end

    always_comb
    begin
        average_mv = held_reg;
        percent    = shown_reg;
        charging   = chg_reg;
        updated    = upd_reg;
    end

    // cell voltage follows the latched average
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_clamp;
    end

endmodule
